// ----- hw/rtl/pale_pkg.sv -----
// Shared types, codes and helpers for the positional array list engine.
package pale_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int TYPE_W       = 3;
   localparam int POS_W        = 7;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 3;
   localparam int INDEX_W      = 6;
   localparam int COUNT_W      = 7;

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR  = 3'd0,
      REQ_INSERT = 3'd1,
      REQ_DELETE = 3'd2,
      REQ_SEARCH = 3'd3,
      REQ_READ   = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [TYPE_W-1:0]         req_type;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] data;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } rsp_payload_type;

   function automatic rsp_payload_type make_rsp(
      input status_type                status,
      input logic [INDEX_W-1:0]        index,
      input logic signed [VALUE_W-1:0] data,
      input logic [COUNT_W-1:0]        count,
      input logic                      last
   );
      rsp_payload_type r;
      r.status = status;
      r.index  = index;
      r.data   = data;
      r.count  = count;
      r.last   = last;
      return r;
   endfunction

endpackage

// ----- hw/rtl/pale_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
interface pale_stream_if #(
   parameter type payload_type = pale_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/pale_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/positional_array_list_engine_unit.sv -----
// Top level of the positional array list engine: sequencer, list RAM and result register.
//
//   channel   dir   beat               accepted when
//   req_if    in    req_payload_type   req_if.valid && req_if.ready
//   rsp_if    out   rsp_payload_type   rsp_if.valid && rsp_if.ready
//
// Moves: every entry move or compare is a RAM read, then a write or
//   compare, since the list RAM has one read port with registered data.
// Reset: synchronous, clears count, sequencer and result valid; RAM holds junk.
// Stalls: req_if.ready is high only while idle; a finished result waits in the
//   output register, so the next request is taken while it is still pending.
//   A search stalls on a further match until the previous one has gone out.
module positional_array_list_engine_unit #(
   parameter int CAPACITY = pale_pkg::CAPACITY_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pale_stream_if.sink   req_if,
   pale_stream_if.source rsp_if
);
   import pale_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
   localparam logic [COUNT_W-1:0] ONE       = COUNT_W'(1);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_INS_RD   = 11'b000_0000_0010,
      S_INS_WR   = 11'b000_0000_0100,
      S_INS_PUT  = 11'b000_0000_1000,
      S_DEL_RD   = 11'b000_0001_0000,
      S_DEL_WR   = 11'b000_0010_0000,
      S_SRCH_RD  = 11'b000_0100_0000,
      S_SRCH_CMP = 11'b000_1000_0000,
      S_RD_ADDR  = 11'b001_0000_0000,
      S_RD_DATA  = 11'b010_0000_0000,
      S_EMIT     = 11'b100_0000_0000
   } state_type;

   // sequencer state
   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     iter_ff, iter_in;      // walking list index
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                   pend_ff, pend_in;      // search: a match is held back
   logic [INDEX_W-1:0]     pend_idx_ff, pend_idx_in;
   rsp_payload_type        res_ff, res_in;        // final answer awaiting the output

   // output register
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_payload_ff;
   logic                   slot_free;
   logic                   load_out;
   rsp_payload_type        out_next;

   // list RAM
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [VALUE_W-1:0]     ram_wdata;
   logic [AW-1:0]          ram_raddr;
   logic [VALUE_W-1:0]     ram_rdata;

   logic                   req_fire;
   logic                   hit;
   logic                   last_scan;
   logic [COUNT_W-1:0]     iter_dec;
   logic [COUNT_W-1:0]     iter_inc;

   pale_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_if.ready   = (state_ff == S_IDLE);
   assign req_fire       = req_if.valid && req_if.ready;
   assign slot_free      = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   assign iter_dec  = iter_ff - ONE;
   assign iter_inc  = iter_ff + ONE;
   assign hit       = (ram_rdata == val_ff);
   assign last_scan = (iter_inc == count_ff);

   // read address: held steady in the compare state so the data stays put on a stall
   always_comb begin
      case (state_ff)
         S_INS_RD:   ram_raddr = iter_dec[AW-1:0];
         S_DEL_RD:   ram_raddr = iter_inc[AW-1:0];
         S_RD_ADDR:  ram_raddr = pos_ff[AW-1:0];
         default:    ram_raddr = iter_ff[AW-1:0];
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      iter_in     = iter_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      res_in      = res_ff;
      ram_we      = 1'b0;
      ram_waddr   = iter_ff[AW-1:0];
      ram_wdata   = ram_rdata;
      load_out    = 1'b0;
      out_next    = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pos_in  = req_if.payload.position;
               val_in  = req_if.payload.value;
               pend_in = 1'b0;
               case (req_if.payload.req_type)
                  REQ_CLEAR: begin
                     count_in = '0;
                     res_in   = make_rsp(ST_OK, '0, '0, '0, 1'b1);
                     state_in = S_EMIT;
                  end
                  REQ_INSERT: begin
                     state_in = S_EMIT;
                     if (count_ff >= CAP_COUNT) begin
                        res_in = make_rsp(ST_FULL, '0, '0, count_ff, 1'b1);
                     end else if (req_if.payload.position > count_ff) begin
                        res_in = make_rsp(ST_BADPOS, '0, '0, count_ff, 1'b1);
                     end else if (req_if.payload.position == count_ff) begin
                        state_in = S_INS_PUT;
                     end else begin
                        iter_in  = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  REQ_DELETE: begin
                     state_in = S_EMIT;
                     if (count_ff == '0) begin
                        res_in = make_rsp(ST_EMPTY, '0, '0, count_ff, 1'b1);
                     end else if (req_if.payload.position >= count_ff) begin
                        res_in = make_rsp(ST_BADPOS, '0, '0, count_ff, 1'b1);
                     end else if ((req_if.payload.position + ONE) < count_ff) begin
                        iter_in  = req_if.payload.position;
                        state_in = S_DEL_RD;
                     end else begin
                        // deleting the tail entry: nothing to move
                        count_in = count_ff - ONE;
                        res_in   = make_rsp(ST_OK, '0, '0, count_ff - ONE, 1'b1);
                     end
                  end
                  REQ_SEARCH: begin
                     if (count_ff == '0) begin
                        res_in   = make_rsp(ST_EMPTY, '0, '0, count_ff, 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        iter_in  = '0;
                        state_in = S_SRCH_RD;
                     end
                  end
                  REQ_READ: begin
                     state_in = S_EMIT;
                     if (count_ff == '0) begin
                        res_in = make_rsp(ST_EMPTY, '0, '0, count_ff, 1'b1);
                     end else if (req_if.payload.position >= count_ff) begin
                        res_in = make_rsp(ST_BADPOS, '0, '0, count_ff, 1'b1);
                     end else begin
                        state_in = S_RD_ADDR;
                     end
                  end
                  default: begin
                     // unknown request: dropped without an answer
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_INS_RD: state_in = S_INS_WR;

         S_INS_WR: begin
            // entry iter-1 moves up to iter
            ram_we   = 1'b1;
            iter_in  = iter_dec;
            state_in = (iter_dec == pos_ff) ? S_INS_PUT : S_INS_RD;
         end

         S_INS_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = val_ff;
            count_in  = count_ff + ONE;
            res_in    = make_rsp(ST_OK, '0, '0, count_ff + ONE, 1'b1);
            state_in  = S_EMIT;
         end

         S_DEL_RD: state_in = S_DEL_WR;

         S_DEL_WR: begin
            // entry iter+1 moves down to iter
            ram_we  = 1'b1;
            iter_in = iter_inc;
            if ((iter_inc + ONE) < count_ff) begin
               state_in = S_DEL_RD;
            end else begin
               count_in = count_ff - ONE;
               res_in   = make_rsp(ST_OK, '0, '0, count_ff - ONE, 1'b1);
               state_in = S_EMIT;
            end
         end

         S_SRCH_RD: state_in = S_SRCH_CMP;

         S_SRCH_CMP: begin
            // a new match releases the held one, which then cannot be the last
            if (!(hit && pend_ff && !slot_free)) begin
               if (hit && pend_ff) begin
                  load_out = 1'b1;
                  out_next = make_rsp(ST_OK, pend_idx_ff, '0, count_ff, 1'b0);
               end
               if (last_scan) begin
                  state_in = S_EMIT;
                  if (hit) begin
                     res_in = make_rsp(ST_OK, iter_ff[INDEX_W-1:0], '0, count_ff, 1'b1);
                  end else if (pend_ff) begin
                     res_in = make_rsp(ST_OK, pend_idx_ff, '0, count_ff, 1'b1);
                  end else begin
                     res_in = make_rsp(ST_NOTFOUND, '0, '0, count_ff, 1'b1);
                  end
               end else begin
                  if (hit) begin
                     pend_in     = 1'b1;
                     pend_idx_in = iter_ff[INDEX_W-1:0];
                  end
                  iter_in  = iter_inc;
                  state_in = S_SRCH_RD;
               end
            end
         end

         S_RD_ADDR: state_in = S_RD_DATA;

         S_RD_DATA: begin
            res_in   = make_rsp(ST_OK, pos_ff[INDEX_W-1:0], ram_rdata, count_ff, 1'b1);
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (slot_free) begin
               load_out = 1'b1;
               out_next = res_ff;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
      if (load_out) begin
         rsp_payload_ff <= out_next;
      end
   end

   // the list never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   // a clear leaves the list empty
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_if.payload.req_type == REQ_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the list");

   // the final insert step grows the list by exactly one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_PUT |=> count_ff == $past(count_ff) + ONE)
      else $error("insert did not bump the count");

   // a match released mid-search is never marked final
   a_search_not_last: assert property (@(posedge clock) disable iff (reset)
      load_out && (state_ff == S_SRCH_CMP) |=> rsp_valid_ff && !rsp_payload_ff.last)
      else $error("intermediate search beat marked last");

   // no RAM write while idle or sending an answer
   a_quiet_ram: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) || (state_ff == S_EMIT) |-> !ram_we)
      else $error("list RAM written outside a move");

endmodule

// ----- sim/list_engine_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the list engine: predicts result beats from accepted requests and compares them.
module list_engine_checker #(
   parameter int CAPACITY = pale_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  pale_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  pale_pkg::rsp_payload_type rsp_payload,
   output int                        error_count,
   output int                        rsp_pending
);
   import pale_pkg::*;

   logic signed [VALUE_W-1:0] list_mem [CAPACITY];
   int                        list_len = 0;
   rsp_payload_type           expected_rsps[$];
   int                        mismatches = 0;

   assign error_count = mismatches;

   task automatic report_mismatch(input string msg);
      $display("%0t ns list check: %s", $time, msg);
      mismatches++;
   endtask

   task automatic push_expected(input status_type st, input int idx,
                                input logic signed [VALUE_W-1:0] d, input logic fin);
      rsp_payload_type r;
      r.status = st;
      r.index  = INDEX_W'(idx);
      r.data   = d;
      r.count  = COUNT_W'(list_len);
      r.last   = fin;
      expected_rsps.push_back(r);
   endtask

   // Apply one request to the shadow list and queue the beats it must produce.
   task automatic predict_request(input req_payload_type req);
      int pos;
      int hits[$];
      pos = req.position;
      case (req.req_type)
         REQ_CLEAR: begin
            list_len = 0;
            push_expected(ST_OK, 0, '0, 1'b1);
         end
         REQ_INSERT: begin
            if (list_len >= CAPACITY) begin
               push_expected(ST_FULL, 0, '0, 1'b1);
            end else if (pos > list_len) begin
               push_expected(ST_BADPOS, 0, '0, 1'b1);
            end else begin
               for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = req.value;
               list_len++;
               push_expected(ST_OK, 0, '0, 1'b1);
            end
         end
         REQ_DELETE: begin
            if (list_len == 0) begin
               push_expected(ST_EMPTY, 0, '0, 1'b1);
            end else if (pos >= list_len) begin
               push_expected(ST_BADPOS, 0, '0, 1'b1);
            end else begin
               for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
               push_expected(ST_OK, 0, '0, 1'b1);
            end
         end
         REQ_SEARCH: begin
            if (list_len == 0) begin
               push_expected(ST_EMPTY, 0, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_len; i++)
                  if (list_mem[i] == req.value) hits.push_back(i);
               if (hits.size() == 0) begin
                  push_expected(ST_NOTFOUND, 0, '0, 1'b1);
               end else begin
                  foreach (hits[k]) push_expected(ST_OK, hits[k], '0, k == hits.size() - 1);
               end
            end
         end
         REQ_READ: begin
            if (list_len == 0) begin
               push_expected(ST_EMPTY, 0, '0, 1'b1);
            end else if (pos >= list_len) begin
               push_expected(ST_BADPOS, 0, '0, 1'b1);
            end else begin
               push_expected(ST_OK, pos, list_mem[pos], 1'b1);
            end
         end
         default: ; // unused codes are dropped without an answer
      endcase
   endtask

   task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                              input logic [VALUE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   task automatic check_beat(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch($sformatf("result beat with none expected (status %0d, count %0d)",
                                   got.status, got.count));
         return;
      end
      want = expected_rsps.pop_front();
      check_field("status", got.status, want.status);
      check_field("index",  got.index,  want.index);
      check_field("data",   got.data,   want.data);
      check_field("count",  got.count,  want.count);
      check_field("last",   got.last,   want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         expected_rsps.delete();
         rsp_pending <= 0;
      end else begin
         if (req_valid && req_ready) predict_request(req_payload);
         if (rsp_valid && rsp_ready) check_beat(rsp_payload);
         rsp_pending <= expected_rsps.size();
      end
   end

endmodule

// ----- sim/positional_array_list_engine_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the list engine: request stimulus, result drain and verdict.
module positional_array_list_engine_unit_tb;
   import pale_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEF;
   localparam int CLK_PERIOD   = 8;
   localparam int RANDOM_ITEMS = 100;
   // worst case: ~140 requests, each a full walk of the list plus 64 match
   // beats that can each sit out a random result stall; taken several times over
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 200;  // room for the longest request to finish
   localparam int HOLD_BEAT    = 20;   // result beat before which the long stall falls
   localparam int HOLD_CYCLES  = 300;

   // request codes the engine must swallow without an answer
   localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int mismatches;
   int pending;

   // stimulus bookkeeping: answered requests sent, and the list length the
   // engine should be holding once all sent requests are done
   int sent    = 0;
   int len_est = 0;

   pale_stream_if #(.payload_type(req_payload_type)) req_if ();
   pale_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   positional_array_list_engine_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   list_engine_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .error_count (mismatches),
      .rsp_pending (pending)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic req_payload_type mk_req(input logic [TYPE_W-1:0] kind, input int pos,
                                              input logic [VALUE_W-1:0] v);
      req_payload_type p;
      p.req_type = kind;
      p.position = POS_W'(pos);
      p.value    = v;
      return p;
   endfunction

   // Values mostly come from a small pool so that searches find several hits;
   // the rest are full-width random to toggle every data bit.
   function automatic logic signed [VALUE_W-1:0] pool_value();
      if ($urandom_range(3, 0) == 0) return $urandom();
      case ($urandom_range(7, 0))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3:       return 32'sd0;
         4:       return 32'sd1;
         5:       return 32'sd42;
         6:       return -32'sd42;
         default: return 32'sd1000;
      endcase
   endfunction

   // Offer one request beat and hold it until the engine takes it. Every third
   // stretch of 16 requests goes back to back with no idle cycles.
   task automatic issue(input req_payload_type p);
      int gap;
      gap = (((sent / 16) % 3) == 2) ? 0 : $urandom_range(7, 0);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      // track the length so positions can be aimed inside the list
      case (p.req_type)
         REQ_CLEAR:  len_est = 0;
         REQ_INSERT: if (len_est < CAPACITY && p.position <= len_est) len_est++;
         REQ_DELETE: if (len_est > 0 && p.position < len_est) len_est--;
         default: ;
      endcase
      if (p.req_type <= REQ_READ) sent++;
   endtask

   // One request from the general mix; most positions land inside the list,
   // some anywhere from 0 to the capacity to hit the bad-position paths.
   task automatic issue_mixed();
      int  pick;
      bit  wild;
      int  pos;
      pick = $urandom_range(99, 0);
      wild = ($urandom_range(99, 0) < 15) || (len_est == 0);
      if (pick < 34) begin
         pos = wild ? $urandom_range(CAPACITY, 0) : $urandom_range(len_est, 0);
         issue(mk_req(REQ_INSERT, pos, pool_value()));
      end else if (pick < 52) begin
         pos = wild ? $urandom_range(CAPACITY, 0) : $urandom_range(len_est - 1, 0);
         issue(mk_req(REQ_DELETE, pos, $urandom()));
      end else if (pick < 72) begin
         issue(mk_req(REQ_SEARCH, $urandom_range(CAPACITY, 0), pool_value()));
      end else if (pick < 90) begin
         pos = wild ? $urandom_range(CAPACITY, 0) : $urandom_range(len_est - 1, 0);
         issue(mk_req(REQ_READ, pos, $urandom()));
      end else if (pick < 97) begin
         issue(mk_req(TYPE_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)),
                      $urandom_range(CAPACITY, 0), $urandom()));
      end else begin
         issue(mk_req(REQ_CLEAR, $urandom_range(CAPACITY, 0), $urandom()));
      end
   endtask

   // Result side: a random stall before each beat, quiet stretches with none, and
   // one long hold-off early on so the output register backs up and the
   // engine stops taking requests while the sender keeps offering them.
   initial begin
      int stall;
      int beats;
      beats = 0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (beats == HOLD_BEAT) stall = HOLD_CYCLES;
         else if (((beats / 20) % 3) == 1) stall = 0;
         else stall = $urandom_range(7, 0);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         beats++;
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("positional_array_list_engine_unit_tb: errors");
      $finish;
   end

   // Request side and verdict
   initial begin
      int first_random;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // everything that needs entries, against an empty list
      issue(mk_req(REQ_SEARCH, 0, 32'sd0));
      issue(mk_req(REQ_READ,   0, 32'sd0));
      issue(mk_req(REQ_DELETE, 0, 32'sd0));
      issue(mk_req(REQ_INSERT, 1, 32'sd5));            // past the end
      // build [-1, max, min, max]: append, front and middle inserts
      issue(mk_req(REQ_INSERT, 0, 32'sh8000_0000));
      issue(mk_req(REQ_INSERT, 1, 32'sh7fff_ffff));
      issue(mk_req(REQ_INSERT, 0, -32'sd1));
      issue(mk_req(REQ_INSERT, 1, 32'sh7fff_ffff));
      issue(mk_req(REQ_SEARCH, 0, 32'sh7fff_ffff));    // two hits
      issue(mk_req(REQ_SEARCH, 0, 32'sd12345));        // no hit
      issue(mk_req(REQ_READ,   3, 32'sd0));            // last entry
      issue(mk_req(REQ_READ,   4, 32'sd0));            // position == count
      issue(mk_req(REQ_READ,   CAPACITY, 32'sd0));     // position == capacity
      issue(mk_req(REQ_DELETE, 4, 32'sd0));            // position == count
      issue(mk_req(REQ_DELETE, 0, 32'sd0));            // front
      issue(mk_req(REQ_DELETE, 2, 32'sd0));            // back
      issue(mk_req(REQ_INSERT, CAPACITY, 32'sd9));     // far past the end
      for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++)
         issue(mk_req(TYPE_W'(k), $urandom_range(CAPACITY, 0), $urandom()));
      issue(mk_req(REQ_SEARCH, 0, 32'sh8000_0000));
      issue(mk_req(REQ_CLEAR,  0, 32'sd0));
      issue(mk_req(REQ_READ,   0, 32'sd0));            // empty again after clear
      issue(mk_req(REQ_INSERT, 0, 32'sd0));
      issue(mk_req(REQ_SEARCH, 0, 32'sd0));

      // --- random ---
      first_random = sent;
      while (sent < first_random + 30) issue_mixed();
      // fill to capacity with random positions, then overflow it
      while (len_est < CAPACITY)
         issue(mk_req(REQ_INSERT, $urandom_range(len_est, 0), pool_value()));
      repeat (2) issue(mk_req(REQ_INSERT, $urandom_range(CAPACITY, 0), pool_value()));
      // long searches and reads across a full list
      repeat (6) issue(mk_req(REQ_SEARCH, 0, pool_value()));
      repeat (4) issue(mk_req(REQ_READ, $urandom_range(CAPACITY - 1, 0), 32'sd0));
      while (sent < first_random + RANDOM_ITEMS) issue_mixed();
      req_if.valid <= 1'b0;

      // drain: the checker count is registered, so wait for it, then give an ignored tail time
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending == 0)
         $display("positional_array_list_engine_unit_tb: clean");
      else
         $display("positional_array_list_engine_unit_tb: errors");
      $finish;
   end

endmodule

// ----- positional_array_list_engine_unit.f -----
hw/rtl/pale_pkg.sv
hw/rtl/pale_stream_if.sv
hw/rtl/pale_ram.sv
hw/rtl/positional_array_list_engine_unit.sv
sim/list_engine_checker.sv
sim/positional_array_list_engine_unit_tb.sv
